FILE: rtl/lstm_cell_inference_step_defines.svh
// Assertion macros shared by the LSTM cell step block.
`ifndef LSTM_CELL_INFERENCE_STEP_DEFINES_SVH
`define LSTM_CELL_INFERENCE_STEP_DEFINES_SVH
// Same-cycle implication, checked on every clock edge outside reset.
`define LCIS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define LCIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/lcis_pkg.sv
// Types, codes and fixed-point helpers for the LSTM cell step block.
package lcis_pkg;

	localparam int ACC_W = 40;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_DATA  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [12:0]        weight_index;
		logic signed [15:0] weight_value;
		logic signed [15:0] x_value;
		logic               x_last;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] y_value;
		logic [3:0]         y_position;
		logic               y_last;
	} out_word_t;

	// State carried by one cell along the chain
	typedef struct packed {
		logic signed [15:0] h;
		logic signed [15:0] c;
		logic signed [15:0] hn;
		logic signed [15:0] cn;
	} cell_word_t;

	typedef struct packed {
		logic clear;
		logic commit;
		logic shift;
	} cell_ctl_t;

	// Round to nearest (floor of sum plus half) and saturate to Q4.12
	function automatic logic signed [15:0] to_q12(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] s;
		t = v + ACC_W'(2048);
		s = t >>> 12;
		if (s > $signed(ACC_W'(32767)))
			to_q12 = 16'sh7fff;
		else if (s < -$signed(ACC_W'(32768)))
			to_q12 = 16'sh8000;
		else
			to_q12 = s[15:0];
	endfunction

	// Piecewise-linear sigmoid, result 0..4096
	function automatic logic signed [13:0] sigmoid_q(input logic signed [16:0] x);
		logic signed [17:0] xe;
		logic [17:0]        a;
		logic [12:0]        s;
		xe = {x[16], x};
		a  = x[16] ? 18'(-xe) : 18'(xe);
		if (a >= 18'd20480)
			s = 13'd4096;
		else if (a >= 18'd9728)
			s = 13'(a >> 5) + 13'd3456;
		else if (a >= 18'd4096)
			s = 13'(a >> 3) + 13'd2560;
		else
			s = 13'(a >> 2) + 13'd2048;
		sigmoid_q = x[16] ? (14'sd4096 - $signed({1'b0, s})) : $signed({1'b0, s});
	endfunction

	// tanh(x) = 2*sigmoid(2x) - 1, result -4096..4096
	function automatic logic signed [13:0] tanh_q(input logic signed [15:0] x);
		logic signed [13:0] s;
		s = sigmoid_q({x, 1'b0});
		tanh_q = (s <<< 1) - 14'sd4096;
	endfunction

endpackage

FILE: rtl/lcis_cell.sv
// One state cell of the hidden/cell state ring.
module lcis_cell import lcis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_word_t nxt,
	output cell_word_t cur
);

	cell_word_t word_q;

	// Hold, clear, commit new state or take the neighbor's word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.clear) begin
			word_q.h <= '0;
			word_q.c <= '0;
		end else if (ctl.commit) begin
			word_q.h <= word_q.hn;
			word_q.c <= word_q.cn;
		end else if (ctl.shift) begin
			word_q <= nxt;
		end
	end

	assign cur = word_q;

endmodule

FILE: rtl/lstm_cell_inference_step.sv
// LSTM cell step with linear output layer, Q4.12, on a ring of state cells.
//
// Input channel: a word is taken when start is high and busy is low.
//   req_type write stores weight_value at weight_index (ignored past the
//   layout); clear zeroes h and c; data buffers x_value. Write, clear and
//   non-last data words leave busy low.
// A data word with x_last starts a cell step: busy rises next cycle.
//   One multiply-accumulate unit walks the weight memory one word per
//   cycle in the issue state while the h/c ring rotates to feed h[j].
//   Each gate issues its bias, I input terms and H hidden terms, then
//   drains; each row then runs S_ACT1 to S_ACT6, a commit follows the
//   last row, and each output issues its bias and H terms, then drains.
//   The step is paced by the single weight memory read port.
// Result channel: O words, each with a one-cycle strobe, y_last on the
//   final one. The receiver cannot stall; each word is valid for one cycle.
// Reset: h, c and the input count clear at once; weight memory and the
//   input buffer hold nothing defined until written.
module lstm_cell_inference_step import lcis_pkg::*; #(
	parameter int INPUT_DIM  = 4,
	parameter int HIDDEN_DIM = 8,
	parameter int OUTPUT_DIM = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  req,
	output logic      busy,
	output logic      strobe,
	output out_word_t result
);

	`include "lstm_cell_inference_step_defines.svh"

	localparam int I = INPUT_DIM;
	localparam int H = HIDDEN_DIM;
	localparam int O = OUTPUT_DIM;
	localparam int BASE_U  = 4 * H * I;
	localparam int BASE_BG = BASE_U + 4 * H * H;
	localparam int BASE_WY = BASE_BG + 4 * H;
	localparam int BASE_BY = BASE_WY + O * H;
	localparam int WMEM_WORDS = BASE_BY + O;
	localparam int MW = $clog2(WMEM_WORDS);
	localparam int HW = (H > 1) ? $clog2(H) : 1;
	localparam int OW = (O > 1) ? $clog2(O) : 1;
	localparam int XW = (I > 1) ? $clog2(I) : 1;
	localparam int CW = $clog2(I + 1);
	localparam int TW = $clog2(I + H + 2);

	typedef enum logic [3:0] {
		S_IDLE, S_ISSUE, S_DRAIN, S_ACT1, S_ACT2, S_ACT3, S_ACT4, S_ACT5, S_ACT6, S_COMMIT
	} state_t;

	state_t state_q;
	logic          out_mode_q;
	logic [HW-1:0] row_q;
	logic [HW-1:0] hj_q;
	logic [1:0]    gate_q;
	logic [OW-1:0] n_q;
	logic [TW-1:0] term_q;
	logic [1:0]    drain_q;
	logic [CW-1:0] xcnt_q;
	logic signed [15:0] xbuf_q [I];
	logic signed [15:0] gpre_q [4];
	logic signed [13:0] fg_q, ig_q, gg_q, og_q, th_q;
	logic signed [29:0] p1_q, p2_q, p3_q;
	logic signed [15:0] cn_q;
	logic      strobe_q;
	out_word_t result_q;

	logic signed [15:0] wmem [WMEM_WORDS];
	logic signed [15:0] rd_q;
	logic               vld_s1, vld_s2;
	logic signed [15:0] op_s1;
	logic signed [31:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic        accept;
	logic        is_bias, is_input, last_term, acc_clr, issue;
	logic [12:0] addr;
	logic [XW-1:0] xj;
	logic signed [15:0] operand;
	logic signed [15:0] hn;

	cell_ctl_t  ctl;
	cell_word_t cells [H];
	cell_word_t head_out;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign issue  = (state_q == S_ISSUE);

	// Decode the current term of the dot product
	always_comb begin
		is_bias  = (term_q == '0);
		is_input = !out_mode_q && !is_bias && (term_q <= TW'(I));
		last_term = out_mode_q ? (term_q == TW'(H)) : (term_q == TW'(I + H));
		xj = XW'(term_q - TW'(1));
		if (is_bias)
			operand = 16'sd4096;
		else if (is_input)
			operand = ((term_q - TW'(1)) < TW'(xcnt_q)) ? xbuf_q[xj] : 16'sd0;
		else
			operand = cells[0].h;
		if (out_mode_q) begin
			if (is_bias)
				addr = 13'(BASE_BY) + 13'(n_q);
			else
				addr = 13'(BASE_WY) + 13'(n_q) * 13'(H) + 13'(hj_q);
		end else begin
			if (is_bias)
				addr = 13'(BASE_BG) + 13'(gate_q) * 13'(H) + 13'(row_q);
			else if (is_input)
				addr = 13'(gate_q) * 13'(H * I) + 13'(row_q) * 13'(I) + 13'(xj);
			else
				addr = 13'(BASE_U) + 13'(gate_q) * 13'(H * H) + 13'(row_q) * 13'(H)
					+ 13'(hj_q);
		end
	end

	// Weight memory: write on accepted write words within the layout, read every cycle
	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_WRITE && req.weight_index < 13'(WMEM_WORDS))
			wmem[MW'(req.weight_index)] <= req.weight_value;
		rd_q <= wmem[MW'(addr)];
	end

	// MAC pipeline: operand, product, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	assign acc_clr = (state_q == S_IDLE) || (state_q == S_DRAIN && drain_q == 2'd2);

	always_ff @(posedge clk) begin
		op_s1   <= operand;
		prod_s2 <= rd_q * op_s1;
		if (acc_clr)
			acc_q <= '0;
		else if (vld_s2)
			acc_q <= acc_q + {{(ACC_W - 32){prod_s2[31]}}, prod_s2};
	end

	// Ring of state cells; head is cell 0, shifting moves each cell i+1 into cell i and the head to the tail
	assign hn = to_q12({{(ACC_W - 30){p3_q[29]}}, p3_q});

	always_comb begin
		ctl.clear  = accept && req.req_type == REQ_CLEAR;
		ctl.commit = (state_q == S_COMMIT);
		ctl.shift  = (issue && !is_bias && !is_input) || (state_q == S_ACT6);
		head_out = cells[0];
		if (state_q == S_ACT6) begin
			head_out.hn = hn;
			head_out.cn = cn_q;
		end
	end

	for (genvar gi = 0; gi < H; gi++) begin : g_cell
		lcis_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.nxt    ((gi == H - 1) ? head_out : cells[(gi + 1) % H]),
			.cur    (cells[gi])
		);
	end

	// Input buffer: keep elements up to INPUT_DIM, drop the rest
	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_DATA && xcnt_q < CW'(I))
			xbuf_q[xcnt_q[XW-1:0]] <= req.x_value;
	end

	// Sequencer: gates per row, activations, commit, then output layer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_mode_q <= 1'b0;
			row_q      <= '0;
			hj_q       <= '0;
			gate_q     <= '0;
			n_q        <= '0;
			term_q     <= '0;
			drain_q    <= '0;
			xcnt_q     <= '0;
			strobe_q   <= 1'b0;
			result_q   <= '0;
			gpre_q     <= '{default: '0};
			fg_q       <= '0;
			ig_q       <= '0;
			gg_q       <= '0;
			og_q       <= '0;
			th_q       <= '0;
			p1_q       <= '0;
			p2_q       <= '0;
			p3_q       <= '0;
			cn_q       <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.req_type == REQ_DATA) begin
						if (xcnt_q < CW'(I))
							xcnt_q <= xcnt_q + CW'(1);
						if (req.x_last) begin
							state_q    <= S_ISSUE;
							out_mode_q <= 1'b0;
							row_q      <= '0;
							gate_q     <= '0;
							hj_q       <= '0;
							term_q     <= '0;
						end
					end
				end
				S_ISSUE: begin
					if (!is_bias && !is_input)
						hj_q <= (hj_q == HW'(H - 1)) ? '0 : hj_q + HW'(1);
					if (last_term) begin
						state_q <= S_DRAIN;
						drain_q <= '0;
					end else begin
						term_q <= term_q + TW'(1);
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						term_q <= '0;
						if (out_mode_q) begin
							strobe_q            <= 1'b1;
							result_q.y_value    <= to_q12(acc_q);
							result_q.y_position <= 4'(n_q);
							result_q.y_last     <= (n_q == OW'(O - 1));
							hj_q                <= '0;
							if (n_q == OW'(O - 1)) begin
								state_q <= S_IDLE;
								xcnt_q  <= '0;
							end else begin
								n_q     <= n_q + OW'(1);
								state_q <= S_ISSUE;
							end
						end else begin
							gpre_q[gate_q] <= to_q12(acc_q);
							hj_q           <= row_q;
							if (gate_q == 2'd3) begin
								state_q <= S_ACT1;
							end else begin
								gate_q  <= gate_q + 2'd1;
								state_q <= S_ISSUE;
							end
						end
					end
				end
				S_ACT1: begin
					fg_q    <= sigmoid_q({gpre_q[0][15], gpre_q[0]});
					ig_q    <= sigmoid_q({gpre_q[1][15], gpre_q[1]});
					gg_q    <= tanh_q(gpre_q[2]);
					og_q    <= sigmoid_q({gpre_q[3][15], gpre_q[3]});
					state_q <= S_ACT2;
				end
				S_ACT2: begin
					p1_q    <= fg_q * cells[0].c;
					p2_q    <= 30'(ig_q * gg_q);
					state_q <= S_ACT3;
				end
				S_ACT3: begin
					cn_q <= to_q12({{(ACC_W - 30){p1_q[29]}}, p1_q}
						+ {{(ACC_W - 30){p2_q[29]}}, p2_q});
					state_q <= S_ACT4;
				end
				S_ACT4: begin
					th_q    <= tanh_q(cn_q);
					state_q <= S_ACT5;
				end
				S_ACT5: begin
					p3_q    <= 30'(og_q * th_q);
					state_q <= S_ACT6;
				end
				S_ACT6: begin
					gate_q <= '0;
					if (row_q == HW'(H - 1)) begin
						state_q <= S_COMMIT;
					end else begin
						row_q   <= row_q + HW'(1);
						hj_q    <= row_q + HW'(1);
						state_q <= S_ISSUE;
					end
				end
				S_COMMIT: begin
					out_mode_q <= 1'b1;
					n_q        <= '0;
					hj_q       <= '0;
					term_q     <= '0;
					state_q    <= S_ISSUE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`LCIS_ASSERT_NOW(a_mid_run_busy, strobe && !result.y_last, busy,
		"result before end of run while block is idle")
	`LCIS_ASSERT_NEXT(a_run_ends, strobe && result.y_last, !strobe,
		"result after final word of run")
	`LCIS_ASSERT_NEXT(a_step_starts,
		start && !busy && req.req_type == REQ_DATA && req.x_last, busy,
		"last element did not start a cell step")

endmodule
